>>> src/pgk_pkg.sv
// Shared constants and types for the pairwise gravity kick pipeline.
// No dependencies; used by pgk_sqrt, pgk_div and pairwise_gravity_kick.
package pgk_pkg;

  localparam int SQ_ST  = 32;
  localparam int QW     = 34;
  localparam int DIV_ST = QW + 1;
  localparam int ST_SQ  = 4;
  localparam int ST_MUL = ST_SQ + SQ_ST;
  localparam int ST_SUM = ST_MUL + 1;
  localparam int ST_DIV = ST_SUM + 1;
  localparam int ST_OUT = ST_DIV + DIV_ST;
  localparam int NSTG   = ST_OUT + 1;

  localparam logic ADDR_GRAV = 1'b0;
  localparam logic ADDR_STEP = 1'b1;

  localparam logic [31:0] GRAV_RST = 32'd65536;
  localparam logic [31:0] STEP_RST = 32'd1092;

  localparam logic [QW-1:0] LIM_POS = 34'h0_7FFF_FFFF;
  localparam logic [QW-1:0] LIM_NEG = 34'h0_8000_0000;

  typedef struct packed {
    logic       k;
    logic [2:0] neg;
    logic [2:0] pos;
    logic       coin;
  } flags_t;

  typedef struct packed {
    logic [95:0]      n_a;
    logic [95:0]      n_b;
    logic [2:0][30:0] e;
    logic [63:0]      ssum;
  } carry_t;

endpackage

>>> src/pgk_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on pgk_pkg for the stage count.
module pgk_sqrt (
  input  logic                       clk,
  input  logic [pgk_pkg::SQ_ST-1:0] en,
  input  logic [63:0]                x,
  output logic [31:0]                root
);

  logic [31:0] q [pgk_pkg::SQ_ST];
  logic [63:0] r [pgk_pkg::SQ_ST-1];

  for (genvar s = 0; s < pgk_pkg::SQ_ST; s++) begin : g_st
    localparam int J = pgk_pkg::SQ_ST - 1 - s;
    logic [31:0] qin;
    logic [63:0] rin;
    logic [65:0] t;
    logic        ge;

    if (s == 0) begin : g_first
      assign qin = '0;
      assign rin = x;
    end else begin : g_next
      assign qin = q[s-1];
      assign rin = r[s-1];
    end

    assign t  = ({34'd0, qin} << (J + 1)) + (66'd1 << (2 * J));
    assign ge = {2'b00, rin} >= t;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        q[s] <= ge ? (qin | (32'd1 << J)) : qin;
      end
    end

    if (s < pgk_pkg::SQ_ST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          r[s] <= ge ? (rin - t[63:0]) : rin;
        end
      end
    end
  end

  assign root = q[pgk_pkg::SQ_ST-1];

endmodule

>>> src/pgk_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on pgk_pkg for quotient width and stage count.
module pgk_div (
  input  logic                        clk,
  input  logic [pgk_pkg::DIV_ST-1:0] en,
  input  logic [127:0]                num,
  input  logic [95:0]                 den,
  output logic [pgk_pkg::QW-1:0]     quot,
  output logic                        ovf
);

  logic [pgk_pkg::QW-1:0] q [pgk_pkg::DIV_ST];
  logic                   o [pgk_pkg::DIV_ST];
  logic [127:0]           r [pgk_pkg::DIV_ST-1];
  logic [95:0]            d [pgk_pkg::DIV_ST-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r[0] <= num;
      d[0] <= den;
      q[0] <= '0;
      o[0] <= {2'b00, num} >= {den, {pgk_pkg::QW{1'b0}}};
    end
  end

  for (genvar s = 1; s < pgk_pkg::DIV_ST; s++) begin : g_st
    localparam int J = pgk_pkg::QW - s;
    logic [129:0] t;
    logic         ge;

    assign t  = {34'd0, d[s-1]} << J;
    assign ge = {2'b00, r[s-1]} >= t;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        q[s] <= q[s-1] | ({{(pgk_pkg::QW-1){1'b0}}, ge} << J);
        o[s] <= o[s-1];
      end
    end

    if (s < pgk_pkg::DIV_ST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          r[s] <= ge ? (r[s-1] - t[127:0]) : r[s-1];
          d[s] <= d[s-1];
        end
      end
    end
  end

  assign quot = q[pgk_pkg::DIV_ST-1];
  assign ovf  = o[pgk_pkg::DIV_ST-1];

endmodule

>>> src/pairwise_gravity_kick.sv
// Pairwise gravity velocity kick: full pipeline top level with APB registers.
// Depends on pgk_pkg, pgk_sqrt and pgk_div.
//
//  port group   dir  beat contents
//  s_t*         in   one body pair (positions, masses)
//  m_t*         out  both velocity increments plus coincident/saturated flags
//  APB          in   grav_const at 0x0, time_step at 0x4
//
// One pair per cycle sustained while the output is ready. Depth is set by the
// 32-stage square root and the 35-stage dividers (six lanes, one per output).
// Empty stages collapse under back-pressure, so input is taken while any
// stage is free. Reset clears stage valids and presets the two registers.
module pairwise_gravity_kick (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dvel_a_x, dvel_a_y, dvel_a_z, dvel_b_x, dvel_b_y, dvel_b_z
  output logic [191:0] m_tdata,
  // coincident, saturated
  output logic [1:0]   m_tuser
);

  localparam logic [pgk_pkg::NSTG-1:0] ONES = '1;

  logic [31:0] grav;
  logic [31:0] step;

  logic [pgk_pkg::NSTG-1:0] v;
  logic [pgk_pkg::NSTG-1:0] en;

  logic [32:0] d [3];
  logic [31:0] ma;
  logic [31:0] mb;

  logic [32:0] mag [3];
  logic        kc;

  logic [30:0] e1 [3];
  logic [63:0] gka;
  logic [63:0] gkb;

  logic [61:0] sq [3];
  logic [30:0] e2 [3];
  logic [63:0] nal;
  logic [63:0] nah;
  logic [63:0] nbl;
  logic [63:0] nbh;

  pgk_pkg::flags_t flg [1:pgk_pkg::ST_OUT-1];
  pgk_pkg::carry_t cr  [pgk_pkg::ST_SQ-1:pgk_pkg::ST_MUL-1];

  logic [31:0] root;

  logic [63:0] dpl;
  logic [63:0] dph;
  logic [63:0] pp [2][3][3];

  logic [95:0]  den;
  logic [127:0] prod [2][3];

  logic [pgk_pkg::QW-1:0] quot [2][3];
  logic                   ovf  [2][3];

  logic [191:0] res_data;
  logic [1:0]   res_user;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= pgk_pkg::GRAV_RST;
      step <= pgk_pkg::STEP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        pgk_pkg::ADDR_GRAV: grav <= pwdata;
        pgk_pkg::ADDR_STEP: step <= pwdata;
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == pgk_pkg::ADDR_STEP) ? step : grav;
  assign pready = 1'b1;

  // stage enables: advance a stage when the output is ready or any stage from it onward is empty
  always_comb begin
    for (int i = 0; i < pgk_pkg::NSTG; i++) begin
      en[i] = m_tready || ((v >> i) != (ONES >> i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < pgk_pkg::NSTG; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[pgk_pkg::ST_OUT];

  // separation
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= {s_tdata[32*(i+3)+31], s_tdata[32*(i+3) +: 32]}
              - {s_tdata[32*i+31], s_tdata[32*i +: 32]};
      end
      ma <= s_tdata[223:192];
      mb <= s_tdata[255:224];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][32] ? (33'd0 - d[i]) : d[i];
    end
    kc = mag[0][31] | mag[1][31] | mag[2][31];
  end

  // range shift, flags, G*m
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]         <= kc ? mag[i][31:1] : mag[i][30:0];
        flg[1].neg[i] <= d[i][32];
        flg[1].pos[i] <= !d[i][32] && (d[i] != 33'd0);
      end
      flg[1].k    <= kc;
      flg[1].coin <= (d[0] == 33'd0) && (d[1] == 33'd0) && (d[2] == 33'd0);
      gka <= {32'd0, grav} * {32'd0, mb};
      gkb <= {32'd0, grav} * {32'd0, ma};
    end
    for (int i = 2; i < pgk_pkg::ST_OUT; i++) begin
      if (en[i]) flg[i] <= flg[i-1];
    end
  end

  // squares, G*m*dt partials
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= {31'd0, e1[i]} * {31'd0, e1[i]};
        e2[i] <= e1[i];
      end
      nal <= {32'd0, gka[31:0]}  * {32'd0, step};
      nah <= {32'd0, gka[63:32]} * {32'd0, step};
      nbl <= {32'd0, gkb[31:0]}  * {32'd0, step};
      nbh <= {32'd0, gkb[63:32]} * {32'd0, step};
    end
  end

  // squared length, numerators
  always_ff @(posedge clk) begin
    if (en[3]) begin
      cr[3].ssum <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
      cr[3].n_a  <= {32'd0, nal} + {nah, 32'd0};
      cr[3].n_b  <= {32'd0, nbl} + {nbh, 32'd0};
      for (int i = 0; i < 3; i++) begin
        cr[3].e[i] <= e2[i];
      end
    end
    for (int i = pgk_pkg::ST_SQ; i < pgk_pkg::ST_MUL; i++) begin
      if (en[i]) cr[i] <= cr[i-1];
    end
  end

  pgk_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[pgk_pkg::ST_MUL-1:pgk_pkg::ST_SQ]),
    .x    (cr[pgk_pkg::ST_SQ-1].ssum),
    .root (root)
  );

  // partial products for r^3 and N*|d|
  always_ff @(posedge clk) begin
    if (en[pgk_pkg::ST_MUL]) begin
      dpl <= {32'd0, cr[pgk_pkg::ST_MUL-1].ssum[31:0]}  * {32'd0, root};
      dph <= {32'd0, cr[pgk_pkg::ST_MUL-1].ssum[63:32]} * {32'd0, root};
      for (int ax = 0; ax < 3; ax++) begin
        for (int w = 0; w < 3; w++) begin
          pp[0][ax][w] <= {32'd0, cr[pgk_pkg::ST_MUL-1].n_a[32*w +: 32]}
                        * {33'd0, cr[pgk_pkg::ST_MUL-1].e[ax]};
          pp[1][ax][w] <= {32'd0, cr[pgk_pkg::ST_MUL-1].n_b[32*w +: 32]}
                        * {33'd0, cr[pgk_pkg::ST_MUL-1].e[ax]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[pgk_pkg::ST_SUM]) begin
      den <= {32'd0, dpl} + {dph, 32'd0};
      for (int b = 0; b < 2; b++) begin
        for (int ax = 0; ax < 3; ax++) begin
          prod[b][ax] <= {64'd0, pp[b][ax][0]} + {32'd0, pp[b][ax][1], 32'd0}
                       + {pp[b][ax][2], 64'd0};
        end
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_body
    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      pgk_div u_div (
        .clk  (clk),
        .en   (en[pgk_pkg::ST_OUT-1:pgk_pkg::ST_DIV]),
        .num  (prod[b][ax]),
        .den  (den),
        .quot (quot[b][ax]),
        .ovf  (ovf[b][ax])
      );
    end
  end

  // scale, sign and clip
  always_comb begin
    pgk_pkg::flags_t        fo;
    logic                   neg;
    logic                   ls;
    logic [pgk_pkg::QW-1:0] qv;
    logic [pgk_pkg::QW-1:0] lim;
    logic [pgk_pkg::QW-1:0] mg;
    fo       = flg[pgk_pkg::ST_OUT-1];
    res_data = '0;
    res_user = '0;
    for (int b = 0; b < 2; b++) begin
      for (int ax = 0; ax < 3; ax++) begin
        neg = (b == 0) ? fo.neg[ax] : fo.pos[ax];
        qv  = fo.k ? {2'b00, quot[b][ax][pgk_pkg::QW-1:2]} : quot[b][ax];
        lim = neg ? pgk_pkg::LIM_NEG : pgk_pkg::LIM_POS;
        ls  = ovf[b][ax] || (qv > lim);
        mg  = ls ? lim : qv;
        if (!fo.coin) begin
          res_data[32*(b*3+ax) +: 32] = neg ? (32'd0 - mg[31:0]) : mg[31:0];
          res_user[1] = res_user[1] | ls;
        end
      end
    end
    res_user[0] = fo.coin;
  end

  always_ff @(posedge clk) begin
    if (en[pgk_pkg::ST_OUT]) begin
      m_tdata <= res_data;
      m_tuser <= res_user;
    end
  end

  a_coin_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tdata == 192'd0))
    else $error("coincident beat carries nonzero increments or saturation");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v) && !m_tready |-> !s_tready)
    else $error("full pipeline accepted a beat while output stalled");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(v) <= $past($countones(v)) + 1)
          && ($countones(v) + 1 >= $past($countones(v))))
    else $error("pipeline occupancy jumped by more than one beat");

endmodule

>>> bench/pairwise_gravity_kick_tb.sv
// Testbench for pairwise_gravity_kick: directed body pairs, then random pairs
// over several register settings and idle patterns, checked beat by beat against
// an in-bench kick predictor. Depends on pgk_pkg and the pairwise_gravity_kick RTL.
module pairwise_gravity_kick_tb;

  typedef struct packed {
    logic [31:0]      mass_b;
    logic [31:0]      mass_a;
    logic [2:0][31:0] pos_b;
    logic [2:0][31:0] pos_a;
  } pair_t;

  typedef struct packed {
    logic             sat;
    logic             coin;
    logic [5:0][31:0] dv;
  } kick_t;

  typedef struct {
    pair_t pair;
    logic  typed;
    kick_t kick;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;

  logic [31:0] grav_cfg = pgk_pkg::GRAV_RST;
  logic [31:0] step_cfg = pgk_pkg::STEP_RST;
  kick_t       kick_q[$];
  kick_t       typed_kick_q[$];
  logic        typed_flag_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  row_t        rows[$];

  pairwise_gravity_kick uut (.*);

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("pairwise_gravity_kick test failed");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clip_kick(input logic [127:0] q, input logic neg,
                                            inout logic sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  function automatic kick_t predict_kick(input pair_t p, input logic [31:0] g,
                                         input logic [31:0] dt);
    logic signed [32:0] d[3];
    logic [31:0]        m[3];
    logic               k;
    logic [63:0]        ssum;
    logic [127:0]       den, num_a, num_b;
    kick_t              r;
    r = '0;
    ssum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({p.pos_b[i][31], p.pos_b[i]}) - $signed({p.pos_a[i][31], p.pos_a[i]});
      m[i] = d[i][32] ? 32'(-d[i]) : d[i][31:0];
    end
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
      r.coin = 1'b1;
      return r;
    end
    k = m[0][31] | m[1][31] | m[2][31];
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      ssum += {32'b0, m[i]} * {32'b0, m[i]};
    end
    den = 128'(ssum) * 128'(int_sqrt(ssum));
    num_a = 128'(g) * 128'(p.mass_b) * 128'(dt);
    num_b = 128'(g) * 128'(p.mass_a) * 128'(dt);
    for (int i = 0; i < 3; i++) begin
      r.dv[i] = clip_kick((num_a * 128'(m[i]) / den) >> (2 * k), d[i][32], r.sat);
      r.dv[3+i] = clip_kick((num_b * 128'(m[i]) / den) >> (2 * k),
                            !d[i][32] && m[i] != 0, r.sat);
    end
    return r;
  endfunction

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    kick_t want, got;
    logic  typed;
    if (!rst && s_tvalid && s_tready) begin
      typed = typed_flag_q.pop_front();
      want = typed_kick_q.pop_front();
      kick_q.push_back(typed ? want : predict_kick(pair_t'(s_tdata), grav_cfg, step_cfg));
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[1], m_tuser[0], m_tdata};
      if (kick_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", got);
      end else begin
        want = kick_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            for (int i = 0; i < 6; i++)
              if (got.dv[i] !== want.dv[i])
                $display("dvel[%0d]: expected %h, got %h", i, want.dv[i], got.dv[i]);
            if (got.coin !== want.coin)
              $display("coincident: expected %b, got %b", want.coin, got.coin);
            if (got.sat !== want.sat)
              $display("saturated: expected %b, got %b", want.sat, got.sat);
          end
        end
      end
    end
  end

  task automatic drain();
    while (kick_q.size() != 0 || typed_flag_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    drain();
    repeat (80) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pgk_pkg::ADDR_GRAV) grav_cfg = v;
    else step_cfg = v;
  endtask

  task automatic send_pair(input pair_t p, input logic typed, input kick_t k);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    typed_flag_q.push_back(typed);
    typed_kick_q.push_back(k);
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic pair_t mk(input logic [31:0] ax, ay, az, bx, by, bz, ma, mb);
    pair_t p;
    p.pos_a = {az, ay, ax};
    p.pos_b = {bz, by, bx};
    p.mass_a = ma;
    p.mass_b = mb;
    return p;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (mode <= 5) begin
        p.pos_a[i] = $signed($urandom) >>> (32 - $urandom_range(16, 30));
        p.pos_b[i] = p.pos_a[i] + ($signed($urandom) >>> (32 - $urandom_range(1, 31)));
      end else if (mode <= 7) begin
        p.pos_a[i] = $urandom;
        p.pos_b[i] = $urandom;
      end else if (mode == 8) begin
        p.pos_a[i] = $urandom;
        p.pos_b[i] = $urandom_range(2) == 0 ? p.pos_a[i] + $urandom_range(3) : p.pos_a[i];
      end else begin
        p.pos_a[i] = pick_extreme();
        p.pos_b[i] = pick_extreme();
      end
    end
    p.mass_a = $urandom >> $urandom_range(0, 32);
    p.mass_b = $urandom >> $urandom_range(0, 32);
    return p;
  endfunction

  initial begin
    row_t  r;
    kick_t zero_kick;
    int    idle_mode[4][2];
    idle_mode = '{'{0, 0}, '{46, 0}, '{0, 46}, '{11, 11}};
    zero_kick = '0;

    r.typed = 1'b1;
    r.kick = zero_kick;
    r.kick.coin = 1'b1;
    r.pair = mk('0, '0, '0, '0, '0, '0, '1, '1);
    rows.push_back(r);
    r.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h1234_5678, '1, '1);
    rows.push_back(r);
    r.kick = zero_kick;
    r.pair = mk('0, '0, '0, 32'h1, '0, '0, '0, '0);
    rows.push_back(r);
    r.kick.sat = 1'b1;
    r.kick.dv[0] = 32'h7FFF_FFFF;
    r.kick.dv[3] = 32'h8000_0000;
    r.pair = mk('0, '0, '0, 32'h1, '0, '0, '1, '1);
    rows.push_back(r);
    r.typed = 1'b0;
    r.pair = mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, '1, '1);
    rows.push_back(r);
    r.pair = mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h1, 32'h1);
    rows.push_back(r);
    r.pair = mk(32'h8000_0000, '0, '0, 32'h7FFF_FFFF, '0, '0, 32'h10000, 32'h20000);
    rows.push_back(r);
    r.pair = mk('0, 32'h000A_0000, '0, '0, '0, '0, 32'h03E8_0000, 32'h0064_0000);
    rows.push_back(r);
    r.pair = mk('0, '0, 32'hFFF6_0000, '0, '0, '0, 32'h0001_0000, 32'h0010_0000);
    rows.push_back(r);
    r.pair = mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'hFFFE_0000,
                32'hFFFD_0000, '1, 32'h1);
    rows.push_back(r);
    r.pair = mk(32'h4000_0000, 32'hC000_0000, 32'h0, 32'hC000_0000, 32'h4000_0000,
                32'h8000_0000, 32'hFFFF_0000, 32'h0000_FFFF);
    rows.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].kick);
    s_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(pgk_pkg::ADDR_GRAV, 32'h0001_0000);
          write_reg(pgk_pkg::ADDR_STEP, '1);
        end
        2: begin
          write_reg(pgk_pkg::ADDR_GRAV, '0);
          write_reg(pgk_pkg::ADDR_STEP, $urandom);
        end
        3: begin
          write_reg(pgk_pkg::ADDR_GRAV, '1);
          write_reg(pgk_pkg::ADDR_STEP, '0);
        end
        4: begin
          write_reg(pgk_pkg::ADDR_GRAV, $urandom);
          write_reg(pgk_pkg::ADDR_STEP, $urandom);
        end
        5: begin
          write_reg(pgk_pkg::ADDR_GRAV, '1);
          write_reg(pgk_pkg::ADDR_STEP, '1);
        end
        6: begin
          write_reg(pgk_pkg::ADDR_GRAV, $urandom_range(32'h4_0000));
          write_reg(pgk_pkg::ADDR_STEP, 1092);
        end
        7: begin
          write_reg(pgk_pkg::ADDR_GRAV, 32'h0001_0000);
          write_reg(pgk_pkg::ADDR_STEP, 32'h0000_0444);
        end
        default: ;
      endcase
      send_idle_pct = idle_mode[ph % 4][0];
      stall_pct = idle_mode[ph % 4][1];
      for (int n = 0; n < 245; n++) begin
        if (n == 120) begin
          s_tvalid <= 1'b0;
          drain();
        end
        send_pair(rand_pair(), 1'b0, zero_kick);
      end
      s_tvalid <= 1'b0;
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("pairwise_gravity_kick test passed");
    end else begin
      $display("pairwise_gravity_kick test failed");
    end
    $finish;
  end
endmodule
